// File: sv/uss_pkg.sv
// Shared types, byte-class constants and range-check functions for the UTF-8 sanitizer.
// Used by uss_step, utf8_stream_sanitizer and uss_checker; depends on nothing.
`default_nettype none
package uss_pkg;

	localparam logic [7:0]  ASCII_MAX    = 8'h7F;
	localparam logic [7:0]  LEAD2_MIN    = 8'hC2;
	localparam logic [7:0]  LEAD2_MAX    = 8'hDF;
	localparam logic [7:0]  LEAD3_MIN    = 8'hE0;
	localparam logic [7:0]  LEAD3_MAX    = 8'hEF;
	localparam logic [7:0]  LEAD4_MIN    = 8'hF0;
	localparam logic [7:0]  LEAD4_MAX    = 8'hF4;
	localparam logic [7:0]  CONT_MIN     = 8'h80;
	localparam logic [7:0]  CONT_MAX     = 8'hBF;
	localparam logic [7:0]  E0_CONT_MIN  = 8'hA0;
	localparam logic [7:0]  ED_LEAD      = 8'hED;
	localparam logic [7:0]  ED_CONT_MAX  = 8'h9F;
	localparam logic [7:0]  F0_CONT_MIN  = 8'h90;
	localparam logic [7:0]  F4_CONT_MAX  = 8'h8F;
	localparam logic [15:0] CAP_RESET    = 16'd256;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_summary;
		logic        changed;
		logic [15:0] out_length;
		logic        end_of_run;
	} out_item_t;

	typedef struct packed {
		logic [2:0][7:0] pend;
		logic [1:0]      pcnt;
		logic [15:0]     emitted;
		logic            dropped;
		logic            stopped;
	} seq_state_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      dcnt;
		logic            summ;
		logic            chg;
		logic [15:0]     len;
	} burst_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		if (b <= ASCII_MAX) n = 3'd1;
		else if (b >= LEAD2_MIN && b <= LEAD2_MAX) n = 3'd2;
		else if (b >= LEAD3_MIN && b <= LEAD3_MAX) n = 3'd3;
		else if (b >= LEAD4_MIN && b <= LEAD4_MAX) n = 3'd4;
		return n;
	endfunction

	function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
			input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_MIN;
		hi = CONT_MAX;
		if (pos == 2'd1) begin
			if (lead == LEAD3_MIN) lo = E0_CONT_MIN;
			else if (lead == ED_LEAD) hi = ED_CONT_MAX;
			else if (lead == LEAD4_MIN) lo = F0_CONT_MIN;
			else if (lead == LEAD4_MAX) hi = F4_CONT_MAX;
		end
		return (b >= lo) && (b <= hi);
	endfunction

endpackage
`default_nettype wire

// File: sv/uss_step.sv
// Next-state and result-burst logic for one byte of the UTF-8 sanitizer.
// Depends on uss_pkg (types, lead_len, cont_ok).
`default_nettype none
module uss_step (
	input  uss_pkg::seq_state_t st,
	input  uss_pkg::in_item_t   item,
	input  logic [15:0]         cap,
	output uss_pkg::seq_state_t nxt,
	output uss_pkg::burst_t     burst
);
	import uss_pkg::*;

	logic [7:0]  b;
	logic [7:0]  lead;
	logic [2:0]  len;
	logic [2:0]  blen;
	logic [1:0]  p;
	logic        do_start;
	logic [16:0] fill_seq;
	logic [16:0] fill_one;

	assign b        = item.in_byte;
	assign lead     = st.pend[0];
	assign len      = lead_len(lead);
	assign blen     = lead_len(b);
	assign p        = st.pcnt;
	assign fill_seq = {1'b0, st.emitted} + {14'd0, len};
	assign fill_one = {1'b0, st.emitted} + 17'd1;

	always_comb begin
		nxt      = st;
		burst    = '0;
		do_start = 1'b0;
		if (st.stopped) begin
			nxt.dropped = 1'b1;
		end else if (p == 2'd0) begin
			do_start = 1'b1;
		end else if ({1'b0, p} < len && cont_ok(lead, p, b)) begin
			if ({1'b0, p} + 3'd1 == len) begin
				if (fill_seq >= {1'b0, cap}) begin
					nxt.stopped = 1'b1;
					nxt.dropped = 1'b1;
					nxt.pcnt    = 2'd0;
				end else begin
					for (int i = 0; i < 3; i++) begin
						if (2'(i) < p) burst.bytes[i] = st.pend[i];
					end
					burst.bytes[p] = b;
					burst.dcnt     = len;
					nxt.emitted    = fill_seq[15:0];
					nxt.pcnt       = 2'd0;
				end
			end else begin
				nxt.pend[p] = b;
				nxt.pcnt    = p + 2'd1;
			end
		end else begin
			nxt.dropped = 1'b1;
			nxt.pcnt    = 2'd0;
			do_start    = 1'b1;
		end

		if (do_start) begin
			if (fill_one >= {1'b0, cap}) begin
				nxt.stopped = 1'b1;
				nxt.dropped = 1'b1;
				nxt.pcnt    = 2'd0;
			end else if (blen == 3'd0) begin
				nxt.dropped = 1'b1;
			end else if (blen == 3'd1) begin
				burst.bytes[0] = b;
				burst.dcnt     = 3'd1;
				nxt.emitted    = fill_one[15:0];
			end else begin
				nxt.pend[0] = b;
				nxt.pcnt    = 2'd1;
			end
		end

		if (item.last) begin
			if (nxt.pcnt != 2'd0) nxt.dropped = 1'b1;
			burst.summ = 1'b1;
			burst.chg  = nxt.dropped;
			burst.len  = nxt.emitted;
			nxt        = '0;
		end
	end

endmodule
`default_nettype wire

// File: sv/utf8_stream_sanitizer.sv
// UTF-8 stream sanitizer: input register, per-byte check, result burst register.
// Depends on uss_pkg and uss_step.
//
// Usage:
//   in channel  : in_valid/in_ready with in_data {in_byte, last}, one source byte per beat.
//   out channel : out_valid/out_ready with out_data {out_byte, is_summary, changed,
//                 out_length, end_of_run}; each byte yields zero to five result beats.
//   cfg port    : cfg_wr_en/cfg_wr_data write out_capacity at once; write only while idle.
//   A byte enters the input register; its burst loads once the burst register is free.
//   Throughput: one byte per cycle while out_ready is high and each byte yields at most
//   one result; more results hold the out port until they drain, since the burst register
//   drains one result per beat and takes the next byte's burst on its final beat.
//   Bytes of a multi-byte sequence are held until the sequence is complete, then released
//   as a burst; the summary beat follows the byte marked last.
//   Reset: channels empty, pending sequence cleared, out_capacity returns to 256.
//   Stall: while out_ready is low the current result holds, the burst waits and the
//   input register fills; in_ready then drops until the burst drains.
`default_nettype none
module utf8_stream_sanitizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  uss_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output uss_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);
	import uss_pkg::*;

	in_item_t   item_s1;
	logic       valid_s1;
	seq_state_t st_q;
	seq_state_t st_nxt;
	burst_t     burst_nxt;
	burst_t     burst_s2;
	logic [15:0] cap_q;
	logic [2:0] rem_q;
	logic [2:0] idx_q;
	logic       burst_free;
	logic       load;
	logic       is_data;

	uss_step u_step (
		.st    (st_q),
		.item  (item_s1),
		.cap   (cap_q),
		.nxt   (st_nxt),
		.burst (burst_nxt)
	);

	assign out_valid  = (rem_q != 3'd0);
	assign burst_free = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready);
	assign load       = valid_s1 && burst_free;
	assign in_ready   = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '0;
			cap_q    <= CAP_RESET;
			rem_q    <= 3'd0;
			idx_q    <= 3'd0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (in_ready) valid_s1 <= in_valid;
			if (load) begin
				st_q  <= st_nxt;
				rem_q <= burst_nxt.dcnt + {2'd0, burst_nxt.summ};
				idx_q <= 3'd0;
			end else if (out_valid && out_ready) begin
				rem_q <= rem_q - 3'd1;
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_data;
		if (load) burst_s2 <= burst_nxt;
	end

	assign is_data = (idx_q < burst_s2.dcnt);

	always_comb begin
		out_data            = '0;
		out_data.end_of_run = (rem_q == 3'd1);
		if (is_data) begin
			out_data.out_byte = burst_s2.bytes[idx_q[1:0]];
		end else begin
			out_data.is_summary = 1'b1;
			out_data.changed    = burst_s2.chg;
			out_data.out_length = burst_s2.len;
		end
	end

endmodule
`default_nettype wire

// File: sv/uss_checker.sv
// Port-level checks for utf8_stream_sanitizer, attached by the bind below.
// Depends on uss_pkg and the top level's ports.
`default_nettype none
module uss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input uss_pkg::out_item_t out_data
);
	import uss_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input beat withdrawn before acceptance");

	a_summary_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_summary |-> out_data.end_of_run)
		else $error("summary beat not marked end of run");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_summary |-> !out_data.changed
			&& out_data.out_length == 16'd0)
		else $error("data beat carries summary fields");

	a_ready_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_ready && !out_valid)
		else $error("block not empty after reset");

endmodule

bind utf8_stream_sanitizer uss_checker u_uss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
